@@ src/ira_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types, codes and helpers of the idle residency accounting block.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int TS_W      = 64;
  localparam int CNT_W     = 32;
  localparam int MASK_BITS = 16;

  localparam logic [1:0] KIND_ENTER   = 2'd0;
  localparam logic [1:0] KIND_REENTER = 2'd1;
  localparam logic [1:0] KIND_WAKE    = 2'd2;

  // state code reported for a wake or when nothing was left
  localparam logic [8:0] NO_STATE = 9'h1FF;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_UPDATE = 3'b100
  } ctrl_state_e;

  // per-cpu record as held in memory
  typedef struct packed {
    logic             active;
    logic [7:0]       cur_state;
    logic [TS_W-1:0]  enter_time;
    logic [CNT_W-1:0] entries;
    logic [CNT_W-1:0] wakeups;
  } cpu_rec_t;

  typedef struct packed {
    logic capture;  // latch the event, read cpu record and entry count
    logic lookup;   // work out duration, read residency total
    logic commit;   // write back and load the result
  } dp_cmd_t;

  typedef struct packed {
    logic hit;      // event belongs to a selected cpu
  } dp_sts_t;

  function automatic logic [CNT_W-1:0] inc_sat32(input logic [CNT_W-1:0] v);
    inc_sat32 = (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

@@ src/ira_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ira_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                logic                clk_i,
  input  wire                logic                we_i,
  input  wire                logic [AW-1:0]       waddr_i,
  input  wire                logic [WIDTH-1:0]    wdata_i,
  input  wire                logic                re_i,
  input  wire                logic [AW-1:0]       raddr_i,
  output                     logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/ira_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer: capture, lookup and update steps for one idle event.
// ----------------------------------------------------------------------------
module ira_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ira_pkg::dp_sts_t sts_i,
  output      ira_pkg::dp_cmd_t cmd_o,
  output      logic             busy_o
);
  import ira_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        // events of unselected cpus are taken and dropped here
        if (start_i && sts_i.hit) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

@@ src/ira_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ira_dp
// Datapath: cpu mask, per-cpu records, per-state totals and result register.
// ----------------------------------------------------------------------------
module ira_dp #(
  parameter int NUM_CPUS   = 16,
  parameter int NUM_STATES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [15:0]      cfg_wdata_i,
  input  wire logic [63:0]      timestamp_ns_i,
  input  wire logic [5:0]       cpu_number_i,
  input  wire logic [8:0]       idle_state_i,
  input  wire ira_pkg::dp_cmd_t cmd_i,
  output      ira_pkg::dp_sts_t sts_o,
  output      logic             result_valid_o,
  output      logic [1:0]       event_kind_o,
  output      logic [63:0]      event_time_o,
  output      logic [63:0]      relative_time_o,
  output      logic [5:0]       event_cpu_o,
  output      logic [8:0]       new_state_o,
  output      logic [8:0]       previous_state_o,
  output      logic [63:0]      idle_duration_o,
  output      logic [63:0]      previous_state_total_o,
  output      logic [31:0]      new_state_entry_count_o,
  output      logic [31:0]      cpu_entry_count_o,
  output      logic [31:0]      cpu_wakeup_count_o
);
  import ira_pkg::*;

  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int RW = $bits(cpu_rec_t);

  // configuration
  logic [15:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  assign sts_o.hit = ({1'b0, cpu_number_i} < 7'(NUM_CPUS)) &&
                     ({1'b0, cpu_number_i} < 7'(MASK_BITS)) &&
                     mask_q[cpu_number_i[3:0]];

  // captured event
  logic [TS_W-1:0] ts_q;
  logic [CW-1:0]   cpu_q;
  logic [8:0]      st_q;
  logic            new_trk_q;
  logic            in_trk;

  assign in_trk = !idle_state_i[8] && ({1'b0, idle_state_i[7:0]} < 9'(NUM_STATES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ts_q      <= timestamp_ns_i;
      cpu_q     <= cpu_number_i[CW-1:0];
      st_q      <= idle_state_i;
      new_trk_q <= in_trk;
    end
  end

  // valid bits stand in for the all-zero reset of the tables
  logic [NUM_CPUS-1:0]   cpu_vld_q;
  logic [NUM_STATES-1:0] tot_vld_q;
  logic [NUM_STATES-1:0] cnt_vld_q;
  logic                  cpu_vld_rd_q;
  logic                  tot_vld_rd_q;
  logic                  cnt_vld_rd_q;

  // memories
  logic [RW-1:0]    cpu_rdata;
  logic [RW-1:0]    cpu_wdata;
  logic [TS_W-1:0]  tot_rdata;
  logic [CNT_W-1:0] cnt_rdata;
  logic [SW-1:0]    tot_raddr;
  logic             tot_we;
  logic             cnt_we;
  logic [TS_W-1:0]  tot_new;
  logic [CNT_W-1:0] cnt_new;

  ira_ram #(.WIDTH(RW), .DEPTH(NUM_CPUS)) u_cpu_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (cpu_q),
    .wdata_i (cpu_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (cpu_number_i[CW-1:0]),
    .rdata_o (cpu_rdata)
  );

  ira_ram #(.WIDTH(TS_W), .DEPTH(NUM_STATES)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_raddr),
    .wdata_i (tot_new),
    .re_i    (cmd_i.lookup),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  ira_ram #(.WIDTH(CNT_W), .DEPTH(NUM_STATES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (st_q[SW-1:0]),
    .wdata_i (cnt_new),
    .re_i    (cmd_i.capture),
    .raddr_i (idle_state_i[SW-1:0]),
    .rdata_o (cnt_rdata)
  );

  // lookup step
  cpu_rec_t        cpu_rd;
  logic [TS_W:0]   diff;
  logic [TS_W:0]   rel_diff;
  logic            leave_q;
  logic            prev_trk_q;
  logic [TS_W-1:0] dur_q;
  logic [TS_W-1:0] rel_q;
  logic [TS_W-1:0] first_q;
  logic            first_vld_q;

  assign cpu_rd    = cpu_vld_rd_q ? cpu_rec_t'(cpu_rdata) : '0;
  assign diff      = {1'b0, ts_q} - {1'b0, cpu_rd.enter_time};
  assign rel_diff  = {1'b0, ts_q} - {1'b0, first_q};
  assign tot_raddr = cpu_rd.cur_state[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      // time running back means nothing is left
      leave_q    <= cpu_rd.active && !diff[TS_W];
      dur_q      <= (cpu_rd.active && !diff[TS_W]) ? diff[TS_W-1:0] : '0;
      prev_trk_q <= ({1'b0, cpu_rd.cur_state} < 9'(NUM_STATES));
      rel_q      <= first_vld_q ? rel_diff[TS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_vld_rd_q <= 1'b0;
      cnt_vld_rd_q <= 1'b0;
      tot_vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        cpu_vld_rd_q <= cpu_vld_q[cpu_number_i[CW-1:0]];
        cnt_vld_rd_q <= in_trk && cnt_vld_q[idle_state_i[SW-1:0]];
      end
      if (cmd_i.lookup) begin
        tot_vld_rd_q <= ({1'b0, cpu_rd.cur_state} < 9'(NUM_STATES)) &&
                        tot_vld_q[tot_raddr];
      end
    end
  end

  // update step
  logic [TS_W:0]    tot_sum;
  logic [TS_W-1:0]  tot_old;
  logic [CNT_W-1:0] cnt_old;
  logic             is_wake;
  cpu_rec_t         cpu_nx;

  assign is_wake = st_q[8];
  assign tot_old = tot_vld_rd_q ? tot_rdata : '0;
  assign cnt_old = cnt_vld_rd_q ? cnt_rdata : '0;
  assign tot_sum = {1'b0, tot_old} + {1'b0, dur_q};
  assign tot_new = tot_sum[TS_W] ? '1 : tot_sum[TS_W-1:0];
  assign cnt_new = inc_sat32(cnt_old);
  assign tot_we  = cmd_i.commit && leave_q && prev_trk_q;
  assign cnt_we  = cmd_i.commit && new_trk_q;

  always_comb begin
    cpu_nx = cpu_rd;
    if (is_wake) begin
      cpu_nx.active  = 1'b0;
      cpu_nx.wakeups = inc_sat32(cpu_rd.wakeups);
    end else begin
      cpu_nx.active     = 1'b1;
      cpu_nx.cur_state  = st_q[7:0];
      cpu_nx.enter_time = ts_q;
      cpu_nx.entries    = inc_sat32(cpu_rd.entries);
    end
  end

  assign cpu_wdata = cpu_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_vld_q      <= '0;
      tot_vld_q      <= '0;
      cnt_vld_q      <= '0;
      first_vld_q    <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.commit;
      if (cmd_i.commit) begin
        cpu_vld_q[cpu_q] <= 1'b1;
        first_vld_q      <= 1'b1;
        if (tot_we) begin
          tot_vld_q[tot_raddr] <= 1'b1;
        end
        if (cnt_we) begin
          cnt_vld_q[st_q[SW-1:0]] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !first_vld_q) begin
      first_q <= ts_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      event_kind_o            <= is_wake ? KIND_WAKE : (leave_q ? KIND_REENTER : KIND_ENTER);
      event_time_o            <= ts_q;
      relative_time_o         <= rel_q;
      event_cpu_o             <= 6'(cpu_q);
      new_state_o             <= is_wake ? NO_STATE : st_q;
      previous_state_o        <= leave_q ? {1'b0, cpu_rd.cur_state} : NO_STATE;
      idle_duration_o         <= dur_q;
      previous_state_total_o  <= (leave_q && prev_trk_q) ? tot_new : '0;
      new_state_entry_count_o <= new_trk_q ? cnt_new : '0;
      cpu_entry_count_o       <= cpu_nx.entries;
      cpu_wakeup_count_o      <= cpu_nx.wakeups;
    end
  end

endmodule
`default_nettype wire

@@ src/idle_residency_accounting.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idle_residency_accounting
// Per-cpu idle state tracking with per-state residency and entry counters.
// ----------------------------------------------------------------------------
// a selected event is captured, then passes the lookup and update states before
//   its result strobe, high for one cycle; an unselected event is dropped at once
// no new selected event is taken while busy: the cpu record read is followed by
//   the residency total read of the state being left, then by the write back
// reset: asynchronous; valid bits make every table read as zero, no sweep
// the receiver cannot stall: each result is shown for exactly one cycle
module idle_residency_accounting #(
  parameter int NUM_CPUS   = 16,
  parameter int NUM_STATES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [63:0]        timestamp_ns_i,
  input  wire logic [5:0]         cpu_number_i,
  input  wire logic signed [8:0]  idle_state_i,
  output      logic               result_valid_o,
  output      logic [1:0]         event_kind_o,
  output      logic [63:0]        event_time_o,
  output      logic [63:0]        relative_time_o,
  output      logic [5:0]         event_cpu_o,
  output      logic signed [8:0]  new_state_o,
  output      logic signed [8:0]  previous_state_o,
  output      logic [63:0]        idle_duration_o,
  output      logic [63:0]        previous_state_total_o,
  output      logic [31:0]        new_state_entry_count_o,
  output      logic [31:0]        cpu_entry_count_o,
  output      logic [31:0]        cpu_wakeup_count_o
);
  import ira_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [8:0] new_state;
  logic [8:0] prev_state;

  ira_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ira_dp #(
    .NUM_CPUS   (NUM_CPUS),
    .NUM_STATES (NUM_STATES)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .timestamp_ns_i          (timestamp_ns_i),
    .cpu_number_i            (cpu_number_i),
    .idle_state_i            (idle_state_i),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .result_valid_o          (result_valid_o),
    .event_kind_o            (event_kind_o),
    .event_time_o            (event_time_o),
    .relative_time_o         (relative_time_o),
    .event_cpu_o             (event_cpu_o),
    .new_state_o             (new_state),
    .previous_state_o        (prev_state),
    .idle_duration_o         (idle_duration_o),
    .previous_state_total_o  (previous_state_total_o),
    .new_state_entry_count_o (new_state_entry_count_o),
    .cpu_entry_count_o       (cpu_entry_count_o),
    .cpu_wakeup_count_o      (cpu_wakeup_count_o)
  );

  assign new_state_o      = new_state;
  assign previous_state_o = prev_state;

`ifndef ASSERT_OFF
  // a result only follows a cycle of work
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // a newly taken transaction never gives a result in the next cycle
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result strobe right after accept");

  // a wake reports no new state
  a_wake_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && event_kind_o == KIND_WAKE) |-> (new_state == NO_STATE))
    else $error("wake result with a new state");

  // a plain enter left nothing behind
  a_enter_nothing_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && event_kind_o == KIND_ENTER) |->
      (prev_state == NO_STATE && idle_duration_o == '0 &&
       previous_state_total_o == '0))
    else $error("enter result reports a left state");
`endif

endmodule
`default_nettype wire
